>>> rtl/fosm_pkg.sv
// package for the first occurrence string matcher: request/result types and defaults
`default_nettype none
package fosm_pkg;

  localparam int MAX_PATTERN_DEF = 32;
  localparam int MAX_TEXT_DEF    = 65536;
  localparam int POS_W           = 16;
  localparam logic [7:0] SPACE_BYTE = 8'h20;

  typedef enum logic [1:0] {
    REQ_CLEAR   = 2'd0,
    REQ_PATTERN = 2'd1,
    REQ_TEXT    = 2'd2,
    REQ_END     = 2'd3
  } req_code_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] data_byte;
  } req_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] match_position;
    logic             truncated;
  } rsp_t;

  typedef struct packed {
    logic       clear;
    logic       append;
    logic [7:0] data;
  } pat_op_t;

  typedef struct packed {
    logic       start;
    logic       shift;
    logic [7:0] data;
  } scan_op_t;

endpackage
`default_nettype wire

>>> rtl/fosm_pattern.sv
// pattern shift register, newest byte at index 0, with its length
`default_nettype none
module fosm_pattern #(
  parameter int MAX_PATTERN = fosm_pkg::MAX_PATTERN_DEF,
  localparam int LEN_W = $clog2(MAX_PATTERN + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire fosm_pkg::pat_op_t op,
  output logic [7:0]             pat [MAX_PATTERN],
  output logic [LEN_W-1:0]       len,
  output logic                   full
);

  assign full = (len == LEN_W'(MAX_PATTERN));

  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0;
    end else if (op.clear) begin
      len <= '0;
    end else if (op.append) begin
      len <= len + LEN_W'(1);
    end
  end

  // payload shift, no reset
  always_ff @(posedge clk) begin
    if (op.append && !op.clear) begin
      pat[0] <= op.data;
      for (int k = 1; k < MAX_PATTERN; k++) begin
        pat[k] <= pat[k-1];
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/fosm_scan.sv
// text window, kept-byte count and first match tracking
`default_nettype none
module fosm_scan #(
  parameter int MAX_PATTERN = fosm_pkg::MAX_PATTERN_DEF,
  parameter int MAX_TEXT    = fosm_pkg::MAX_TEXT_DEF,
  localparam int LEN_W = $clog2(MAX_PATTERN + 1),
  localparam int CNT_W = $clog2(MAX_TEXT + 1)
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire fosm_pkg::scan_op_t       op,
  input  wire logic [7:0]               pat [MAX_PATTERN],
  input  wire logic [LEN_W-1:0]         len,
  output logic                          match_seen,
  output logic [fosm_pkg::POS_W-1:0]    first_index,
  output logic                          full
);

  localparam int DW = (CNT_W > fosm_pkg::POS_W) ? CNT_W : fosm_pkg::POS_W;

  logic [7:0]       win      [MAX_PATTERN];
  logic [7:0]       win_next [MAX_PATTERN];
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [MAX_PATTERN-1:0] byte_ok;
  logic             hit;
  logic [CNT_W-1:0] diff;
  logic [DW-1:0]    diff_ext;

  assign full       = (count == CNT_W'(MAX_TEXT));
  assign count_next = count + CNT_W'(1);

  always_comb begin
    win_next[0] = op.data;
    for (int k = 1; k < MAX_PATTERN; k++) begin
      win_next[k] = win[k-1];
    end
  end

  // pattern is right aligned: pat[k] lines up with win_next[k]
  always_comb begin
    for (int k = 0; k < MAX_PATTERN; k++) begin
      byte_ok[k] = (LEN_W'(k) >= len) || (pat[k] == win_next[k]);
    end
  end

  assign hit      = (&byte_ok) && (len != '0) && (CNT_W'(len) <= count_next);
  assign diff     = count_next - CNT_W'(len);
  assign diff_ext = DW'(diff);

  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      match_seen  <= 1'b0;
      first_index <= '0;
    end else if (op.start) begin
      count       <= '0;
      match_seen  <= 1'b0;
      first_index <= '0;
    end else if (op.shift) begin
      count <= count_next;
      if (!match_seen && hit) begin
        match_seen  <= 1'b1;
        first_index <= diff_ext[fosm_pkg::POS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (op.shift && !op.start) begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
        win[k] <= win_next[k];
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/first_occurrence_string_matcher.sv
// top level of the first occurrence string matcher: request stage, decode, result register
//
//   channel | signals                    | payload
//   --------+----------------------------+---------------------------------------
//   request | req_valid, req_ready, req  | req_type, data_byte
//   result  | rsp_valid, rsp_ready, rsp  | found, match_position, truncated
//
// one request per cycle unless an end of text request waits in the request register;
// an end of text request passes from the request register to the result register.
// the window compare is one parallel byte equality check over MAX_PATTERN bytes.
// reset clears pattern length, text count, flags and both valid bits.
// an end of text request waits in the request register only while a result is held.
`default_nettype none
module first_occurrence_string_matcher #(
  parameter int MAX_PATTERN = fosm_pkg::MAX_PATTERN_DEF,
  parameter int MAX_TEXT    = fosm_pkg::MAX_TEXT_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_ready,
  input  wire fosm_pkg::req_t req,
  output logic                rsp_valid,
  input  wire logic           rsp_ready,
  output fosm_pkg::rsp_t      rsp
);

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);

  logic                          s1_valid;
  fosm_pkg::req_t                s1;
  logic                          s1_go;
  logic                          rsp_free;
  logic                          rsp_load;
  logic                          ovf_set;
  logic                          overflow_seen;
  logic                          nonspace;
  fosm_pkg::pat_op_t             pat_op;
  fosm_pkg::scan_op_t            scan_op;
  logic [7:0]                    pat [MAX_PATTERN];
  logic [LEN_W-1:0]              len;
  logic                          pat_full;
  logic                          scan_full;
  logic                          match_seen;
  logic [fosm_pkg::POS_W-1:0]    first_index;
  fosm_pkg::rsp_t                rsp_next;

  assign rsp_free  = !rsp_valid || rsp_ready;
  assign s1_go     = s1_valid &&
                     ((s1.req_type != fosm_pkg::REQ_END) || rsp_free);
  assign req_ready = !s1_valid || s1_go;
  assign nonspace  = (s1.data_byte != fosm_pkg::SPACE_BYTE);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_ready) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      s1 <= req;
    end
  end

  always_comb begin
    pat_op        = '0;
    scan_op       = '0;
    pat_op.data   = s1.data_byte;
    scan_op.data  = s1.data_byte;
    ovf_set       = 1'b0;
    rsp_load      = 1'b0;
    if (s1_go) begin
      case (s1.req_type)
        fosm_pkg::REQ_CLEAR: begin
          pat_op.clear  = 1'b1;
          scan_op.start = 1'b1;
        end
        fosm_pkg::REQ_PATTERN: begin
          if (nonspace) begin
            if (pat_full) ovf_set = 1'b1;
            else pat_op.append = 1'b1;
          end
        end
        fosm_pkg::REQ_TEXT: begin
          if (nonspace) begin
            if (scan_full) ovf_set = 1'b1;
            else scan_op.shift = 1'b1;
          end
        end
        fosm_pkg::REQ_END: begin
          scan_op.start = 1'b1;
          rsp_load      = 1'b1;
        end
        default: begin
          rsp_load = 1'b0;
        end
      endcase
    end
  end

  fosm_pattern #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_pattern (
    .clk  (clk),
    .rst  (rst),
    .op   (pat_op),
    .pat  (pat),
    .len  (len),
    .full (pat_full)
  );

  fosm_scan #(
    .MAX_PATTERN(MAX_PATTERN),
    .MAX_TEXT   (MAX_TEXT)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .op          (scan_op),
    .pat         (pat),
    .len         (len),
    .match_seen  (match_seen),
    .first_index (first_index),
    .full        (scan_full)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      overflow_seen <= 1'b0;
    end else if (pat_op.clear) begin
      overflow_seen <= 1'b0;
    end else if (ovf_set) begin
      overflow_seen <= 1'b1;
    end
  end

  // empty pattern matches at zero
  always_comb begin
    rsp_next.truncated = overflow_seen;
    if (len == '0) begin
      rsp_next.found          = 1'b1;
      rsp_next.match_position = '0;
    end else if (match_seen) begin
      rsp_next.found          = 1'b1;
      rsp_next.match_position = first_index;
    end else begin
      rsp_next.found          = 1'b0;
      rsp_next.match_position = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

endmodule
`default_nettype wire

>>> rtl/fosm_checker.sv
// port level checks for the first occurrence string matcher, bound to the top level
`default_nettype none
module fosm_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           req_valid,
  input wire logic           req_ready,
  input wire fosm_pkg::req_t req,
  input wire logic           rsp_valid,
  input wire logic           rsp_ready,
  input wire fosm_pkg::rsp_t rsp
);

  // a held result keeps its payload
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  a_pos_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.found |-> rsp.match_position == '0)
    else $error("position nonzero without a match");

  // a fresh result comes from an end of text request taken into the request register
  a_rsp_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |->
      $past(req_valid && req_ready && (req.req_type == fosm_pkg::REQ_END), 2))
    else $error("result without an end of text request");

  // with no result held the request side never stalls
  a_no_stall: assert property (@(posedge clk)
    !rsp_valid |-> req_ready)
    else $error("request stalled with empty result register");

endmodule

bind first_occurrence_string_matcher fosm_checker u_fosm_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
`default_nettype wire
